// ===== rtl/polynomial_easing_curve_defines.svh =====
// Assertion macros used by the easing curve checker.
`ifndef POLYNOMIAL_EASING_CURVE_DEFINES_SVH
`define POLYNOMIAL_EASING_CURVE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, muted while rst_ni is low.
`define PEC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, muted while rst_ni is low.
`define PEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pec_pkg.sv =====
// Shared constants, codes and types of the polynomial easing curve.
`timescale 1ns / 1ps

package pec_pkg;

  localparam int unsigned FracBitsDefault = 16;

  localparam int unsigned DegreeW  = 3;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 3;

  localparam logic [DegreeW-1:0] DegreeMin   = 3'd2;
  localparam logic [DegreeW-1:0] DegreeMax   = 3'd5;
  localparam logic [DegreeW-1:0] DegreeReset = 3'd2;

  // One multiplier cell per multiplication of the highest power.
  localparam int unsigned NumCells  = 4;
  localparam int unsigned PipeDepth = NumCells + 2;
  localparam int unsigned CntW      = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_DEGREE        = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CURVE_KIND    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_EASING_ENABLE = 2'd2;

  typedef enum logic [KindW-1:0] {
    KIND_IN     = 2'd0,
    KIND_OUT    = 2'd1,
    KIND_IN_OUT = 2'd2,
    KIND_OUT_IN = 2'd3
  } curve_kind_e;

  // Final step applied to the power p.
  typedef enum logic [2:0] {
    POST_DIRECT   = 3'd0,  // p
    POST_INV      = 3'd1,  // 1 - p
    POST_HALF     = 3'd2,  // p / 2
    POST_INV_HALF = 3'd3,  // 1 - p / 2
    POST_HALF_INV = 3'd4,  // (1 - p) / 2
    POST_HALF_UP  = 3'd5   // p / 2 + 1/2
  } post_e;

  typedef struct packed {
    logic [DegreeW-1:0] degree;
    curve_kind_e        kind;
    logic               enable;
  } pec_cfg_t;

  typedef struct packed {
    logic [CntW-1:0] mul_cnt;
    post_e           post;
  } pec_ctrl_t;

endpackage

// ===== rtl/pec_if.sv =====
// Request channels of the easing curve: time samples in, eased values out.
`timescale 1ns / 1ps

interface pec_time_if import pec_pkg::*; #(
  parameter int unsigned W = FracBitsDefault + 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] time_in;

  modport source (output valid, output time_in, input ready);
  modport sink (input valid, input time_in, output ready);
endinterface

interface pec_eased_if import pec_pkg::*; #(
  parameter int unsigned W = FracBitsDefault + 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] eased_value;

  modport source (output valid, output eased_value, input ready);
  modport sink (input valid, input eased_value, output ready);
endinterface

// ===== rtl/pec_front.sv =====
// Entry stage: clamp time, pick the power base and the final step; with easing off, pass raw time.
`timescale 1ns / 1ps

module pec_front import pec_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pec_cfg_t             cfg_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [FRAC_BITS:0]   time_in_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [FRAC_BITS:0]   p_o,
  output logic [FRAC_BITS:0]   x_o,
  output pec_ctrl_t            ctrl_o
);

  localparam int unsigned W = FRAC_BITS + 1;
  localparam logic [W-1:0] One  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [W-1:0] Half = {2'b01, {(FRAC_BITS - 1){1'b0}}};

  logic               valid_q;
  logic [W-1:0]       x_q, x_d;
  pec_ctrl_t          ctrl_q, ctrl_d;
  logic [W-1:0]       t;
  logic [W-1:0]       om_t;
  logic [W:0]         two_t;
  logic [W:0]         two_t_m1;
  logic               below_half;
  logic [DegreeW-1:0] n;

  assign t          = (time_in_i > One) ? One : time_in_i;
  assign om_t       = One - t;
  assign two_t      = {t, 1'b0};
  assign two_t_m1   = two_t - {1'b0, One};
  assign below_half = (t < Half);

  always_comb begin
    if (cfg_i.degree < DegreeMin) begin
      n = DegreeMin;
    end else if (cfg_i.degree > DegreeMax) begin
      n = DegreeMax;
    end else begin
      n = cfg_i.degree;
    end
  end

  always_comb begin
    x_d            = t;
    ctrl_d.mul_cnt = CntW'(n - DegreeW'(1));
    ctrl_d.post    = POST_DIRECT;
    if (!cfg_i.enable) begin
      x_d            = time_in_i;
      ctrl_d.mul_cnt = '0;
    end else begin
      case (cfg_i.kind)
        KIND_IN: begin
          x_d         = t;
          ctrl_d.post = POST_DIRECT;
        end
        KIND_OUT: begin
          x_d         = om_t;
          ctrl_d.post = POST_INV;
        end
        KIND_IN_OUT: begin
          if (below_half) begin
            x_d         = two_t[W-1:0];
            ctrl_d.post = POST_HALF;
          end else begin
            x_d         = {om_t[W-2:0], 1'b0};
            ctrl_d.post = POST_INV_HALF;
          end
        end
        KIND_OUT_IN: begin
          if (below_half) begin
            x_d         = One - two_t[W-1:0];
            ctrl_d.post = POST_HALF_INV;
          end else begin
            x_d         = two_t_m1[W-1:0];
            ctrl_d.post = POST_HALF_UP;
          end
        end
        default: begin
          x_d         = t;
          ctrl_d.post = POST_DIRECT;
        end
      endcase
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      x_q    <= x_d;
      ctrl_q <= ctrl_d;
    end
  end

  assign valid_o = valid_q;
  assign p_o     = x_q;
  assign x_o     = x_q;
  assign ctrl_o  = ctrl_q;

endmodule

// ===== rtl/pec_cell.sv =====
// One multiplier cell: p = (p * x) >> FRAC_BITS when its turn is due.
`timescale 1ns / 1ps

module pec_cell import pec_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDefault,
  parameter int unsigned IDX       = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [FRAC_BITS:0] p_i,
  input  logic [FRAC_BITS:0] x_i,
  input  pec_ctrl_t          ctrl_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [FRAC_BITS:0] p_o,
  output logic [FRAC_BITS:0] x_o,
  output pec_ctrl_t          ctrl_o
);

  localparam int unsigned W = FRAC_BITS + 1;
  localparam logic [CntW-1:0] CellIdx = CntW'(IDX);

  logic           valid_q;
  logic [W-1:0]   p_q, p_d;
  logic [W-1:0]   x_q;
  pec_ctrl_t      ctrl_q;
  logic [2*W-1:0] prod;

  assign prod = {{W{1'b0}}, p_i} * {{W{1'b0}}, x_i};
  // Skip the multiply once this item's power is complete.
  assign p_d  = (CellIdx < ctrl_i.mul_cnt) ? prod[FRAC_BITS +: W] : p_i;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      p_q    <= p_d;
      x_q    <= x_i;
      ctrl_q <= ctrl_i;
    end
  end

  assign valid_o = valid_q;
  assign p_o     = p_q;
  assign x_o     = x_q;
  assign ctrl_o  = ctrl_q;

endmodule

// ===== rtl/pec_back.sv =====
// Exit stage: apply the final step to the power and hold the result.
`timescale 1ns / 1ps

module pec_back import pec_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [FRAC_BITS:0] p_i,
  input  pec_ctrl_t          ctrl_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [FRAC_BITS:0] eased_o
);

  localparam int unsigned W = FRAC_BITS + 1;
  localparam logic [W-1:0] One  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [W-1:0] Half = {2'b01, {(FRAC_BITS - 1){1'b0}}};

  logic         valid_q;
  logic [W-1:0] eased_q, eased_d;
  logic [W-1:0] p_half;
  logic [W-1:0] inv;

  assign p_half = p_i >> 1;
  assign inv    = One - p_i;

  always_comb begin
    case (ctrl_i.post)
      POST_DIRECT:   eased_d = p_i;
      POST_INV:      eased_d = inv;
      POST_HALF:     eased_d = p_half;
      POST_INV_HALF: eased_d = One - p_half;
      POST_HALF_INV: eased_d = inv >> 1;
      POST_HALF_UP:  eased_d = p_half + Half;
      default:       eased_d = p_i;
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      eased_q <= eased_d;
    end
  end

  assign valid_o = valid_q;
  assign eased_o = eased_q;

endmodule

// ===== rtl/polynomial_easing_curve.sv =====
// Polynomial easing curve (quad to quint) over a row of multiplier cells.
// A request passes the entry register, each cell register and the exit register before eased_o.
// Throughput: one request per cycle; each stage holds while its successor is full.
// Reset: clears all stage valid bits; degree 2, curve in, easing enabled.
// Payload registers are not reset.
`timescale 1ns / 1ps

module polynomial_easing_curve import pec_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  pec_time_if.sink            time_i,
  pec_eased_if.source         eased_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned W = FRAC_BITS + 1;

  // Configuration registers; the user must write them only while the pipe is empty (not enforced).
  pec_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.degree <= DegreeReset;
      cfg_q.kind   <= KIND_IN;
      cfg_q.enable <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEGREE:        cfg_q.degree <= cfg_data_i[DegreeW-1:0];
        REG_CURVE_KIND:    cfg_q.kind   <= curve_kind_e'(cfg_data_i[KindW-1:0]);
        REG_EASING_ENABLE: cfg_q.enable <= cfg_data_i[0];
        default: begin
          // Drop writes to indexes without a register.
        end
      endcase
    end
  end

  // Stage links: link k feeds cell k, link NumCells feeds the exit stage.
  logic            valid  [NumCells+1];
  logic            ready  [NumCells+1];
  logic [W-1:0]    p      [NumCells+1];
  logic [W-1:0]    x      [NumCells];
  pec_ctrl_t       ctrl   [NumCells+1];

  // Entry: clamp time, choose the base (t, 1-t, 2t, ...) and the final step.
  pec_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .valid_i   (time_i.valid),
    .ready_o   (time_i.ready),
    .time_in_i (time_i.time_in),
    .valid_o   (valid[0]),
    .ready_i   (ready[0]),
    .p_o       (p[0]),
    .x_o       (x[0]),
    .ctrl_o    (ctrl[0])
  );

  // Each cell performs one multiply of the power, or passes p on once
  // the request's degree is reached, so all degrees share the same latency.
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    if (k < NumCells - 1) begin : g_mid
      pec_cell #(
        .FRAC_BITS (FRAC_BITS),
        .IDX       (k)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .valid_i (valid[k]),
        .ready_o (ready[k]),
        .p_i     (p[k]),
        .x_i     (x[k]),
        .ctrl_i  (ctrl[k]),
        .valid_o (valid[k+1]),
        .ready_i (ready[k+1]),
        .p_o     (p[k+1]),
        .x_o     (x[k+1]),
        .ctrl_o  (ctrl[k+1])
      );
    end else begin : g_last
      // The base is not needed past the last multiply.
      pec_cell #(
        .FRAC_BITS (FRAC_BITS),
        .IDX       (k)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .valid_i (valid[k]),
        .ready_o (ready[k]),
        .p_i     (p[k]),
        .x_i     (x[k]),
        .ctrl_i  (ctrl[k]),
        .valid_o (valid[k+1]),
        .ready_i (ready[k+1]),
        .p_o     (p[k+1]),
        .x_o     (),
        .ctrl_o  (ctrl[k+1])
      );
    end
  end

  // Exit: 1-p, halving or offset, into the output register.
  pec_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid[NumCells]),
    .ready_o (ready[NumCells]),
    .p_i     (p[NumCells]),
    .ctrl_i  (ctrl[NumCells]),
    .valid_o (eased_o.valid),
    .ready_i (eased_o.ready),
    .eased_o (eased_o.eased_value)
  );

endmodule

// ===== rtl/pec_checker.sv =====
// Port-level checks of the easing curve, bound to the top level.
`timescale 1ns / 1ps
`include "polynomial_easing_curve_defines.svh"

module pec_checker import pec_pkg::*; #(
  parameter int unsigned W = FracBitsDefault + 1
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid_i,
  input logic         in_ready_i,
  input logic         out_valid_i,
  input logic         out_ready_i,
  input logic [W-1:0] out_data_i
);

  logic       in_acc;
  logic       out_acc;
  logic [3:0] pending_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Requests accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {3'b000, in_acc} - {3'b000, out_acc};
    end
  end

  `PEC_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_data_i), "stalled result changed or vanished")
  `PEC_ASSERT_NOW(a_ready_when_drained, !out_valid_i, in_ready_i,
    "input stalled while output register is empty")
  `PEC_ASSERT_NOW(a_no_invented, out_valid_i, pending_q != 4'd0,
    "result shown without a pending request")
  `PEC_ASSERT_NOW(a_depth_bound, 1'b1, pending_q <= 4'(PipeDepth),
    "more requests in flight than pipeline stages")

endmodule

bind polynomial_easing_curve pec_checker #(
  .W (FRAC_BITS + 1)
) u_pec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (time_i.valid),
  .in_ready_i  (time_i.ready),
  .out_valid_i (eased_o.valid),
  .out_ready_i (eased_o.ready),
  .out_data_i  (eased_o.eased_value)
);

// ===== sim/polynomial_easing_curve_tb.sv =====
// Self-checking testbench for the polynomial easing curve with random handshake idling.
`timescale 1ns / 1ps

module polynomial_easing_curve_tb;
  import pec_pkg::*;

  localparam int unsigned FracBits  = FracBitsDefault;
  localparam int unsigned W         = FracBits + 1;
  localparam int unsigned ResetLen  = 8;
  localparam int unsigned IdleLimit = 2000;
  // Index 3 names no register; a write there must change nothing.
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
  // Handshake idling modes for either side.
  localparam int unsigned IDLE_NONE   = 0;
  localparam int unsigned IDLE_NORMAL = 1;
  localparam int unsigned IDLE_HEAVY  = 2;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  pec_time_if  #(.W(W)) time_if ();
  pec_eased_if #(.W(W)) eased_if ();

  polynomial_easing_curve #(.FRAC_BITS(FracBits)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .time_i     (time_if),
    .eased_o    (eased_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the configuration registers, updated on every write.
  logic [DegreeW-1:0] model_degree;
  curve_kind_e        model_kind;
  logic               model_enable;

  logic [W-1:0] pending_eased[$];
  logic [W-1:0] expected_eased;
  int unsigned  mismatch_count;
  int unsigned  quiet_cycles;
  int unsigned  src_mode;
  int unsigned  sink_mode;
  int unsigned  sink_stall_left;

  // Gap length in cycles: mostly none or short, now and then long.
  function automatic int unsigned idle_len(input int unsigned mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (mode == IDLE_NONE) return 0;
    if (r < ((mode == IDLE_HEAVY) ? 30 : 70)) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Power by repeated multiply, truncating each product to FracBits fraction bits.
  function automatic longint unsigned raise_fixed(input longint unsigned x,
                                                  input int unsigned n);
    longint unsigned p;
    p = x;
    for (int unsigned i = 1; i < n; i++) p = (p * x) >> FracBits;
    return p;
  endfunction

  function automatic logic [W-1:0] predict_eased(input logic [W-1:0] raw);
    longint unsigned one_fx;
    longint unsigned half_fx;
    longint unsigned t;
    longint unsigned r;
    int unsigned     n;
    one_fx  = 64'd1 << FracBits;
    half_fx = one_fx >> 1;
    t       = (raw > one_fx) ? one_fx : raw;
    n       = model_degree;
    if (n < DegreeMin) n = DegreeMin;
    if (n > DegreeMax) n = DegreeMax;
    // Pass the raw sample through, without clamping.
    if (!model_enable) return raw;
    case (model_kind)
      KIND_IN:  r = raise_fixed(t, n);
      KIND_OUT: r = one_fx - raise_fixed(one_fx - t, n);
      KIND_IN_OUT: begin
        if (t < half_fx) r = raise_fixed(t << 1, n) >> 1;
        else r = one_fx - (raise_fixed((one_fx - t) << 1, n) >> 1);
      end
      default: begin
        if (t < half_fx) r = (one_fx - raise_fixed(one_fx - (t << 1), n)) >> 1;
        else r = (raise_fixed((t << 1) - one_fx, n) >> 1) + half_fx;
      end
    endcase
    return r[W-1:0];
  endfunction

  // Mostly in-range times, with the clamp region and the corners mixed in.
  function automatic logic [W-1:0] rand_time();
    int unsigned one_fx;
    one_fx = 1 << FracBits;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0:       return '0;
          1:       return W'(1);
          2:       return W'(one_fx / 2 - 1);
          3:       return W'(one_fx / 2);
          4:       return W'(one_fx / 2 + 1);
          5:       return W'(one_fx - 1);
          default: return W'(one_fx);
        endcase
      end
      1:       return W'($urandom_range(one_fx + 1, (1 << W) - 1));
      default: return W'($urandom_range(0, one_fx));
    endcase
  endfunction

  // Present one request after a random gap; hold it until accepted.
  task automatic send_time(input logic [W-1:0] t);
    int unsigned gap;
    gap = idle_len(src_mode);
    if (gap != 0) begin
      time_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    time_if.valid   <= 1'b1;
    time_if.time_in <= t;
    do @(posedge clk_i); while (!time_if.ready);
    pending_eased.push_back(predict_eased(t));
  endtask

  // Drop valid, wait out every outstanding result, then let the pipeline settle.
  task automatic wait_for_results();
    time_if.valid <= 1'b0;
    while (pending_eased.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  // One register write; the caller drops the write enable after its last write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_DEGREE:        model_degree = data;
      REG_CURVE_KIND:    model_kind   = curve_kind_e'(data[KindW-1:0]);
      REG_EASING_ENABLE: model_enable = data[0];
      default: ;
    endcase
  endtask

  // Write all three registers while idle; unused upper data bits get random values.
  task automatic apply_config(input logic [DegreeW-1:0] deg, input curve_kind_e kind,
                              input logic en);
    logic [CfgDataW-1:0] kind_word;
    logic [CfgDataW-1:0] en_word;
    kind_word             = CfgDataW'($urandom_range(0, (1 << CfgDataW) - 1));
    kind_word[KindW-1:0]  = kind;
    en_word               = CfgDataW'($urandom_range(0, (1 << CfgDataW) - 1));
    en_word[0]            = en;
    wait_for_results();
    write_reg(REG_DEGREE, deg);
    write_reg(REG_CURVE_KIND, kind_word);
    write_reg(REG_EASING_ENABLE, en_word);
    cfg_we_i <= 1'b0;
  endtask

  // Corners of time under the reset configuration: quad, in, enabled.
  task automatic test_time_corners();
    send_time('0);
    send_time(W'(1));
    send_time(W'(32767));
    send_time(W'(32768));
    send_time(W'(32769));
    send_time(W'(65535));
    send_time(W'(65536));
    send_time(W'(65537));
    send_time('1);
  endtask

  // With easing off, time comes back unchanged, even above one.
  task automatic test_passthrough_corners();
    apply_config(3'd5, KIND_OUT_IN, 1'b0);
    send_time('0);
    send_time(W'(65536));
    send_time(W'(65537));
    send_time('1);
    send_time(W'(43690));
  endtask

  // Degrees below two act as quad, above five as quint; index 3 is ignored.
  task automatic test_degree_limits();
    apply_config(3'd0, KIND_OUT_IN, 1'b1);
    wait_for_results();
    write_reg(REG_UNUSED, '1);
    cfg_we_i <= 1'b0;
    send_time(W'(40000));
    send_time(W'(20000));
    apply_config(3'd1, KIND_IN_OUT, 1'b1);
    send_time(W'(30000));
    apply_config(3'd6, KIND_OUT, 1'b1);
    send_time(W'(50000));
    apply_config(3'd7, KIND_IN_OUT, 1'b1);
    send_time(W'(32768));
    send_time(W'(10000));
  endtask

  // Every curve at every degree code, each with its own idling pattern.
  task automatic test_curve_sweep();
    for (int k = 0; k < 4; k++) begin
      for (int d = 0; d < 8; d++) begin
        apply_config(DegreeW'(d), curve_kind_e'(k), 1'b1);
        src_mode  = $urandom_range(IDLE_NONE, IDLE_HEAVY);
        sink_mode = $urandom_range(IDLE_NONE, IDLE_HEAVY);
        repeat (55) send_time(rand_time());
      end
    end
  endtask

  task automatic test_passthrough_random();
    apply_config(DegreeW'($urandom_range(0, 7)), curve_kind_e'($urandom_range(0, 3)), 1'b0);
    src_mode  = IDLE_NORMAL;
    sink_mode = IDLE_NORMAL;
    repeat (150) send_time(rand_time());
  endtask

  // Hold the sender until the pipeline has returned every result, then resume.
  task automatic test_drain_pause();
    apply_config(3'd3, KIND_IN_OUT, 1'b1);
    sink_mode = IDLE_HEAVY;
    for (int b = 0; b < 4; b++) begin
      src_mode = (b % 2 == 0) ? IDLE_NONE : IDLE_NORMAL;
      repeat (25) send_time(rand_time());
      wait_for_results();
    end
  endtask

  // Sink side: ready with random stall stretches.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      eased_if.ready  <= 1'b0;
      sink_stall_left = 0;
    end else if (sink_stall_left != 0) begin
      eased_if.ready  <= 1'b0;
      sink_stall_left = sink_stall_left - 1;
    end else begin
      sink_stall_left = idle_len(sink_mode);
      eased_if.ready  <= (sink_stall_left == 0);
      if (sink_stall_left != 0) sink_stall_left = sink_stall_left - 1;
    end
  end

  // Compare each accepted result against the oldest outstanding prediction.
  always @(posedge clk_i) begin
    if (rst_ni && eased_if.valid && eased_if.ready) begin
      if (pending_eased.size() == 0) begin
        $error("eased_value: no request outstanding, got %0d", eased_if.eased_value);
        mismatch_count++;
      end else begin
        expected_eased = pending_eased.pop_front();
        if (eased_if.eased_value !== expected_eased) begin
          $error("eased_value: expected %0d, got %0d", expected_eased, eased_if.eased_value);
          mismatch_count++;
        end
      end
    end
  end

  // Abort when neither channel has moved a request for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (time_if.valid && time_if.ready) || (eased_if.valid && eased_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    time_if.valid   = 1'b0;
    time_if.time_in = '0;
    eased_if.ready  = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_DEGREE;
    cfg_data_i      = '0;
    model_degree    = DegreeReset;
    model_kind      = KIND_IN;
    model_enable    = 1'b1;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    sink_stall_left = 0;
    src_mode        = IDLE_NORMAL;
    sink_mode       = IDLE_NORMAL;
    repeat (ResetLen) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_time_corners();
    test_passthrough_corners();
    test_degree_limits();
    test_curve_sweep();
    test_passthrough_random();
    test_drain_pause();
    wait_for_results();
    repeat (PipeDepth * 4) @(posedge clk_i);

    if (mismatch_count == 0 && pending_eased.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
